[design/plist_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg
// Shared sizes, status codes and the shift command for the positional list.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int POS_W     = 5;
    localparam int LEN_OUT_W = 5;
    localparam int IDX_W     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic                  start;
        logic                  del;
        logic [IDX_W-1:0]      start_idx;
        logic [IDX_W-1:0]      stop_idx;
        logic [DATA_WIDTH-1:0] value;
    } t_shift_cmd;

endpackage

[design/plist_shifter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_shifter
// Entry storage with a one-move-per-cycle shift sequencer for insert/delete.
// ----------------------------------------------------------------------------
module plist_shifter import plist_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_shift_cmd i_cmd,
    output logic       o_busy
);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic                  r_busy;
    logic                  r_del;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_stop;
    logic [DATA_WIDTH-1:0] r_val;

    logic [IDX_W-1:0]      n_rd_idx;
    logic                  n_last;

    // single read port: neighbor below on insert, neighbor above on delete
    assign n_rd_idx  = r_del ? (r_idx + IDX_W'(1)) : (r_idx - IDX_W'(1));
    assign n_last    = (r_idx == r_stop);
    assign o_busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && n_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_del  <= i_cmd.del;
            r_idx  <= i_cmd.start_idx;
            r_stop <= i_cmd.stop_idx;
            r_val  <= i_cmd.value;
        end else if (r_busy) begin
            if (!n_last) begin
                r_mem[r_idx] <= r_mem[n_rd_idx];
                r_idx        <= n_rd_idx;
            end else if (!r_del) begin
                // gap is open: drop the new word in
                r_mem[r_idx] <= r_val;
            end
        end
    end

endmodule

[design/positional_list_insert_delete_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered list of signed words with insert and delete at a 1-based position.
// ----------------------------------------------------------------------------
// Timing: a refused request gives its result in the cycle after acceptance;
//   a done request gives its result once the shifter has moved its entries.
// Throughput: one request at a time; the shifter moves one entry per cycle.
// Reset: synchronous, active low; length clears to zero, entries are left
//   as they are and are only read after being written.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core import plist_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_action,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [31:0]      i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [LEN_OUT_W-1:0]    o_length_after
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [LEN_W-1:0]       r_len;
    logic                   r_out_valid;
    t_status                r_status;
    logic [LEN_OUT_W-1:0]   r_out_len;

    logic                   n_accept;
    logic                   n_slot_free;
    logic [CMP_W-1:0]       n_pos_x;
    logic [CMP_W-1:0]       n_len_x;
    logic                   n_ins_ok;
    logic                   n_del_ok;
    logic                   n_full;
    t_status                n_status;
    logic [LEN_W-1:0]       n_len;
    logic [IDX_W-1:0]       n_k;
    logic                   n_finish;
    logic                   w_busy;
    t_shift_cmd             n_cmd;

    assign n_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && n_slot_free;
    assign n_accept    = i_in_valid && o_in_ready;

    assign n_pos_x  = CMP_W'(i_position);
    assign n_len_x  = CMP_W'(r_len);
    assign n_ins_ok = (i_position != '0) && (n_pos_x <= n_len_x + CMP_W'(1));
    assign n_del_ok = (i_position != '0) && (n_pos_x <= n_len_x);
    assign n_full   = (n_len_x == CMP_W'(CAPACITY));
    assign n_k      = IDX_W'(n_pos_x - CMP_W'(1));

    always_comb begin
        n_status = ST_DONE;
        n_len    = r_len;
        if (!i_action) begin
            if (!n_ins_ok) begin
                n_status = ST_INVALID;
            end else if (n_full) begin
                n_status = ST_FULL;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
        end else begin
            if (!n_del_ok) begin
                n_status = ST_INVALID;
            end else begin
                n_len = r_len - LEN_W'(1);
            end
        end
    end

    always_comb begin
        n_cmd.start     = n_accept && (n_status == ST_DONE);
        n_cmd.del       = i_action;
        n_cmd.start_idx = i_action ? n_k : IDX_W'(r_len);
        n_cmd.stop_idx  = i_action ? IDX_W'(r_len - LEN_W'(1)) : n_k;
        n_cmd.value     = DATA_WIDTH'($unsigned(i_value));
    end

    plist_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (n_cmd),
        .o_busy  (w_busy)
    );

    // shift finished and the result slot can take the beat
    assign n_finish = (r_state == S_BUSY) && !w_busy && n_slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (n_cmd.start) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (n_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_accept) begin
                r_len <= n_len;
            end
            if ((n_accept && (n_status != ST_DONE)) || n_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_status  <= n_status;
            r_out_len <= LEN_OUT_W'(n_len);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_length_after = r_out_len;

endmodule

[bench/tb_positional_list_insert_delete_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete_core
// Drives insert and delete requests at random and directed positions and
// checks status and length of every result against a shadow copy of the list.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete_core import plist_pkg::*;;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   BLOCKS = 16;
    localparam int   BLOCK_ITEMS = 40;

    typedef struct {
        logic                  action;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
        int                    gap;
        bit                    drain;
    } t_list_request;

    typedef struct {
        t_status               status;
        logic [LEN_OUT_W-1:0]  len_after;
    } t_list_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_action = ACT_INSERT;
    logic [POS_W-1:0]       i_position = '0;
    logic signed [31:0]     i_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [1:0]             o_status;
    logic [LEN_OUT_W-1:0]   o_length_after;

    t_list_request          request_q[$];
    t_list_result           pending_results[$];
    logic [DATA_WIDTH-1:0]  list_words[$];

    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  rx_stall = 0;
    int  rx_cycle = 0;
    bit  rx_quiet = 1'b0;
    bit  tx_quiet = 1'b0;
    int  gen_len = 0;

    positional_list_insert_delete_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_length_after (o_length_after)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Apply one request to the shadow list and return the resulting status.
    function automatic t_status apply_list_request(input logic act,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_WIDTH-1:0] val);
        int p;
        p = int'(pos);
        if (act == ACT_INSERT) begin
            if (p < 1 || p > list_words.size() + 1) return ST_INVALID;
            if (list_words.size() >= CAPACITY) return ST_FULL;
            list_words.insert(p - 1, val);
        end else begin
            if (p < 1 || p > list_words.size()) return ST_INVALID;
            list_words.delete(p - 1);
        end
        return ST_DONE;
    endfunction

    // Queue a request; track the length it leaves so positions can be aimed.
    task automatic add_request(input logic act, input int pos,
                               input logic [DATA_WIDTH-1:0] val, input bit drain);
        t_list_request req;
        req.action = act;
        req.pos    = POS_W'(pos);
        req.value  = val;
        req.gap    = tx_quiet ? 0 : pick_gap();
        req.drain  = drain;
        request_q.push_back(req);
        if (act == ACT_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
            gen_len++;
        else if (act == ACT_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Request driver: hold the beat until taken, then gap or present the next.
    always @(negedge i_clk) begin
        t_list_request req;
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (request_q.size() != 0 &&
                         !(request_q[0].drain && pending_results.size() != 0)) begin
                req = request_q.pop_front();
                i_in_valid <= 1'b1;
                i_action   <= req.action;
                i_position <= req.pos;
                i_value    <= req.value;
                send_gap   = req.gap;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, with stretches of none.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0) rx_quiet = ~rx_quiet;
        if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!rx_quiet && $urandom_range(0, 5) == 0) rx_stall = pick_gap();
        end
    end

    // Monitor: check result beats, predict on request beats, watch for a hang.
    always @(posedge i_clk) begin
        t_list_result exp_res;
        t_status      st;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (out_fire) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status %0d length %0d",
                                          o_status, o_length_after));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              exp_res.status, o_status));
                if (o_length_after !== exp_res.len_after)
                    report_mismatch($sformatf("length expected %0d got %0d",
                                              exp_res.len_after, o_length_after));
            end
        end
        if (in_fire) begin
            st = apply_list_request(i_action, i_position, i_value);
            exp_res.status    = st;
            exp_res.len_after = LEN_OUT_W'(list_words.size());
            pending_results.push_back(exp_res);
        end
        if (in_fire || out_fire) idle_cycles = 0;
        else if (i_rst_n) idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("positional_list_insert_delete_core: mismatch");
            $finish;
        end
    end

    initial begin
        int mode;
        int act;
        // Empty list: every delete and any insert not at position 1 is refused.
        add_request(ACT_DELETE, 0, '0, 1'b0);
        add_request(ACT_DELETE, 31, '1, 1'b0);
        add_request(ACT_INSERT, 0, 32'h1234_5678, 1'b0);
        add_request(ACT_INSERT, 2, 32'h1234_5678, 1'b0);
        // Front, back and middle inserts with extreme words.
        add_request(ACT_INSERT, 1, 32'h7FFF_FFFF, 1'b0);
        add_request(ACT_INSERT, 2, 32'h8000_0000, 1'b0);
        add_request(ACT_INSERT, 1, 32'hFFFF_FFFF, 1'b0);
        add_request(ACT_INSERT, 2, 32'h0000_0000, 1'b0);
        add_request(ACT_INSERT, 31, 32'h5555_AAAA, 1'b0);
        // Deletes: past the end, middle (value ignored), back, front.
        add_request(ACT_DELETE, 5, '0, 1'b0);
        add_request(ACT_DELETE, 2, '1, 1'b0);
        add_request(ACT_DELETE, 3, 32'hDEAD_BEEF, 1'b0);
        add_request(ACT_DELETE, 1, '0, 1'b0);
        // Fill up, then hit the full list.
        while (gen_len < CAPACITY)
            add_request(ACT_INSERT, $urandom_range(1, gen_len + 1), pick_value(), 1'b0);
        add_request(ACT_INSERT, CAPACITY + 1, 32'h0F0F_0F0F, 1'b0);
        add_request(ACT_INSERT, 5, 32'hF0F0_F0F0, 1'b0);
        add_request(ACT_INSERT, CAPACITY + 2, 32'hF0F0_F0F0, 1'b0);
        add_request(ACT_DELETE, CAPACITY + 1, '0, 1'b0);
        add_request(ACT_DELETE, CAPACITY, '0, 1'b0);

        // Random blocks: balanced, insert-heavy or delete-heavy, with some noise.
        for (int b = 0; b < BLOCKS; b++) begin
            mode = $urandom_range(0, 2);
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                bit drain;
                drain = (k == 0) && (b == 0 || $urandom_range(0, 1) == 1);
                if ($urandom_range(0, 99) < 15) begin
                    add_request(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom,
                                drain);
                end else begin
                    act = $urandom_range(0, 99);
                    if ((mode == 0 && act < 50) || (mode == 1 && act < 80) ||
                        (mode == 2 && act < 20))
                        add_request(ACT_INSERT, $urandom_range(1, gen_len + 1),
                                    pick_value(), drain);
                    else if (gen_len == 0)
                        add_request(ACT_DELETE, 1, $urandom, drain);
                    else
                        add_request(ACT_DELETE, $urandom_range(1, gen_len), $urandom, drain);
                end
            end
        end
        tx_quiet = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (request_q.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (CAPACITY + 5) @(posedge i_clk);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (errors == 0)
            $display("positional_list_insert_delete_core: match");
        else
            $display("positional_list_insert_delete_core: mismatch");
        $finish;
    end

endmodule

[positional_list_insert_delete_core.f]
design/plist_pkg.sv
design/plist_shifter.sv
design/positional_list_insert_delete_core.sv
bench/tb_positional_list_insert_delete_core.sv
